// ===== hw/rtl/pccm_pkg.sv =====
// ============================================================================
// pccm_pkg: shared definitions for the prepaid channel credit meter
// Field widths, billing constants, register indexes and divider sizing.
// ============================================================================
package pccm_pkg;

  // Default number of metered channels.
  localparam int unsigned CHANNELS_DEF = 10;

  // Field widths.
  localparam int unsigned CHANNEL_W = 4;
  localparam int unsigned MINUTES_W = 10;
  localparam int unsigned CURRENT_W = 12;
  localparam int unsigned CREDIT_W  = 14;
  localparam int unsigned MULT_W    = 5;
  localparam int unsigned DEDUCT_W  = 8;

  // Divider sizing: ten times a current sample over a base current.
  localparam int unsigned DIVIDEND_W = 16;
  localparam int unsigned DIVISOR_W  = CURRENT_W;

  // Configuration port.
  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  // Register indexes (word address bits of paddr).
  localparam logic [1:0] REG_POWER_MODE  = 2'd0;
  localparam logic [1:0] REG_BASE_CURRENT = 2'd1;
  localparam logic [1:0] REG_OC_MULTIPLE = 2'd2;

  // Request codes.
  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Billing constants.
  localparam logic [CREDIT_W-1:0]  CREDIT_MAX    = 14'd9999;
  localparam logic [DEDUCT_W-1:0]  PLAIN_RATE    = 8'd10;
  localparam logic [DEDUCT_W-1:0]  DEDUCT_MAX    = 8'd255;
  localparam logic                 POWER_MODE_ON = 1'b1;

  // Register reset values.
  localparam logic                 POWER_MODE_RST = 1'b0;
  localparam logic [CURRENT_W-1:0] BASE_RST       = 12'd100;
  localparam logic [MULT_W-1:0]    MULT_RST       = 5'd3;

endpackage

// ===== hw/rtl/pccm_divider.sv =====
// ============================================================================
// pccm_divider: serial restoring divider
// Produces one quotient bit per cycle; a done pulse follows the last step.
// ============================================================================
module pccm_divider (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [pccm_pkg::DIVIDEND_W-1:0]   dividend,
  input  logic [pccm_pkg::DIVISOR_W-1:0]    divisor,
  output logic                              done,
  output logic [pccm_pkg::DIVIDEND_W-1:0]   quotient
);

  localparam int unsigned DD_W  = pccm_pkg::DIVIDEND_W;
  localparam int unsigned DS_W  = pccm_pkg::DIVISOR_W;
  localparam int unsigned CNT_W = $clog2(DD_W);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DD_W - 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DS_W-1:0]  rem_r, rem_nxt;
  logic [DS_W-1:0]  dsr_r, dsr_nxt;
  logic [DD_W-1:0]  quo_r, quo_nxt;

  logic [DS_W:0]    trial;
  logic [DS_W:0]    diff;
  logic             fits;

  // One step: shift the next dividend bit into the partial remainder and
  // subtract the divisor when it fits.
  assign trial = {rem_r, quo_r[DD_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign fits  = trial >= {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[DS_W-1:0] : trial[DS_W-1:0];
      quo_nxt = {quo_r[DD_W-2:0], fits};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == LAST_STEP) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== hw/rtl/prepaid_channel_credit_meter_core.sv =====
// ============================================================================
// prepaid_channel_credit_meter_core: per-channel prepaid credit metering
// Adds bought minutes and bills one-minute ticks against a credit store.
// ============================================================================
//
//  Channel   Direction  Handshake            Word carried
//  --------  ---------  -------------------  -----------------------------------
//  in_*      input      in_valid / in_ready  event: type, channel, minutes, ...
//  out_*     output     out_valid/out_ready  channel, credit, save request
//  config    input      psel/penable/pready  power mode, base current, multiple
//
//  An add event or a plain tick passes ST_LOAD, ST_APPLY and ST_FINISH, which
//  registers its result, and frees in_ready for a new word back in ST_IDLE; a
//  current-multiple tick also runs the 16-step serial divider in ST_DIV.
//  One word is in flight; a result stalled by out_ready blocks only the
//  finish of the next word, which then waits in the sequencer.
//  rst_n is synchronous and clears the credit store and configuration.
//
module prepaid_channel_credit_meter_core #(
  parameter int unsigned CHANNELS = pccm_pkg::CHANNELS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Event input
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_req_type,
  input  logic [pccm_pkg::CHANNEL_W-1:0]   in_channel,
  input  logic [pccm_pkg::MINUTES_W-1:0]   in_add_minutes,
  input  logic [pccm_pkg::CURRENT_W-1:0]   in_current_sample,
  input  logic                             in_fuse_ok,
  input  logic                             in_over_current,
  // Result output
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [pccm_pkg::CHANNEL_W-1:0]   out_result_channel,
  output logic [pccm_pkg::CREDIT_W-1:0]    out_credit_tenths,
  output logic                             out_save_request,
  // Configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pccm_pkg::PADDR_W-1:0]     paddr,
  input  logic [pccm_pkg::PDATA_W-1:0]     pwdata,
  output logic [pccm_pkg::PDATA_W-1:0]     prdata,
  output logic                             pready
);

  localparam int unsigned CH_W   = pccm_pkg::CHANNEL_W;
  localparam int unsigned CR_W   = pccm_pkg::CREDIT_W;
  localparam int unsigned CU_W   = pccm_pkg::CURRENT_W;
  localparam int unsigned MN_W   = pccm_pkg::MINUTES_W;
  localparam int unsigned MU_W   = pccm_pkg::MULT_W;
  localparam int unsigned DE_W   = pccm_pkg::DEDUCT_W;
  localparam int unsigned DD_W   = pccm_pkg::DIVIDEND_W;
  localparam int unsigned DW     = pccm_pkg::PDATA_W;
  localparam int unsigned IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CHK_W  = CH_W + 1;
  localparam logic [CHK_W-1:0] CH_LIMIT = CHK_W'(CHANNELS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_APPLY,
    ST_FINISH
  } state_t;

  state_t            state_r, state_nxt;

  // Event word held for the duration of the item.
  logic              req_r, req_nxt;
  logic [CH_W-1:0]   ch_r, ch_nxt;
  logic [MN_W-1:0]   mins_r, mins_nxt;
  logic [CU_W-1:0]   cur_r, cur_nxt;
  logic              fuse_r, fuse_nxt;
  logic              oc_r, oc_nxt;

  // Working values.
  logic [CR_W-1:0]   credit_r, credit_nxt;
  logic [DE_W-1:0]   ded_r, ded_nxt;
  logic [CR_W-1:0]   res_credit_r, res_credit_nxt;
  logic              res_save_r, res_save_nxt;

  // Output register.
  logic              out_valid_r, out_valid_nxt;
  logic [CH_W-1:0]   out_ch_r, out_ch_nxt;
  logic [CR_W-1:0]   out_credit_r, out_credit_nxt;
  logic              out_save_r, out_save_nxt;

  // Configuration registers.
  logic              power_mode_r;
  logic [CU_W-1:0]   base_r;
  logic [MU_W-1:0]   mult_r;

  // Credit store, one entry per channel.
  logic [CR_W-1:0]   store_r [CHANNELS];
  logic              store_we;

  logic              ch_ok;
  logic [IDX_W-1:0]  ch_idx;
  logic [DD_W-1:0]   cur_x10;
  logic [CR_W-1:0]   mins_x10;
  logic [CR_W:0]     add_sum;
  logic [MU_W+3:0]   oc_x10;
  logic              cur_above;
  logic              use_div;
  logic [DE_W-1:0]   ded_sel;
  logic              div_start;
  logic              div_done;
  logic [DD_W-1:0]   div_quo;
  logic              cfg_we;

  // Channels at or beyond CHANNELS leave the store untouched and report zero.
  assign ch_ok  = {1'b0, ch_r} < CH_LIMIT;
  assign ch_idx = ch_r[IDX_W-1:0];

  // Multiplications by ten as shift-and-add.
  assign cur_x10  = (DD_W'(cur_r) << 3) + (DD_W'(cur_r) << 1);
  assign mins_x10 = (CR_W'(mins_r) << 3) + (CR_W'(mins_r) << 1);
  assign oc_x10   = ((MU_W+4)'(mult_r) << 3) + ((MU_W+4)'(mult_r) << 1);
  assign add_sum  = {1'b0, credit_r} + {1'b0, mins_x10};

  assign cur_above = cur_r > base_r;

  // The divider is needed only for an in-range current multiple with a
  // nonzero base; a zero base charges the maximum deduction instead.
  assign use_div = (req_r == pccm_pkg::REQ_TICK) &&
                   (power_mode_r == pccm_pkg::POWER_MODE_ON) &&
                   !oc_r && fuse_r && cur_above && (base_r != '0);

  always_comb begin
    if (power_mode_r != pccm_pkg::POWER_MODE_ON) begin
      ded_sel = pccm_pkg::PLAIN_RATE;
    end else if (oc_r) begin
      ded_sel = (oc_x10 > (MU_W+4)'(pccm_pkg::DEDUCT_MAX)) ?
                pccm_pkg::DEDUCT_MAX : oc_x10[DE_W-1:0];
    end else if (fuse_r && cur_above) begin
      ded_sel = pccm_pkg::DEDUCT_MAX;
    end else begin
      ded_sel = pccm_pkg::PLAIN_RATE;
    end
  end

  pccm_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (cur_x10),
    .divisor  (base_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Sequencer: accept, read the store and pick the deduction, optionally
  // run the divider, apply the event, then hand the result to the output
  // register and write the store back.
  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    ch_nxt         = ch_r;
    mins_nxt       = mins_r;
    cur_nxt        = cur_r;
    fuse_nxt       = fuse_r;
    oc_nxt         = oc_r;
    credit_nxt     = credit_r;
    ded_nxt        = ded_r;
    res_credit_nxt = res_credit_r;
    res_save_nxt   = res_save_r;
    out_valid_nxt  = out_valid_r;
    out_ch_nxt     = out_ch_r;
    out_credit_nxt = out_credit_r;
    out_save_nxt   = out_save_r;
    div_start      = 1'b0;
    store_we       = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_req_type;
          ch_nxt    = in_channel;
          mins_nxt  = in_add_minutes;
          cur_nxt   = in_current_sample;
          fuse_nxt  = in_fuse_ok;
          oc_nxt    = in_over_current;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        credit_nxt = ch_ok ? store_r[ch_idx] : '0;
        ded_nxt    = ded_sel;
        if (use_div) begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_APPLY;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          ded_nxt   = (div_quo[DD_W-1:DE_W] != '0) ? pccm_pkg::DEDUCT_MAX :
                      div_quo[DE_W-1:0];
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (!ch_ok) begin
          res_credit_nxt = '0;
          res_save_nxt   = 1'b0;
        end else if (req_r == pccm_pkg::REQ_ADD) begin
          res_credit_nxt = (add_sum > {1'b0, pccm_pkg::CREDIT_MAX}) ?
                           pccm_pkg::CREDIT_MAX : add_sum[CR_W-1:0];
          res_save_nxt   = 1'b1;
        end else if (credit_r > CR_W'(ded_r)) begin
          res_credit_nxt = credit_r - CR_W'(ded_r);
          res_save_nxt   = 1'b0;
        end else begin
          // Credit used up: a nonzero balance is cleared and must be saved.
          res_credit_nxt = '0;
          res_save_nxt   = (credit_r != '0);
        end
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_ch_nxt     = ch_r;
          out_credit_nxt = res_credit_r;
          out_save_nxt   = res_save_r;
          store_we       = ch_ok;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r        <= req_nxt;
    ch_r         <= ch_nxt;
    mins_r       <= mins_nxt;
    cur_r        <= cur_nxt;
    fuse_r       <= fuse_nxt;
    oc_r         <= oc_nxt;
    credit_r     <= credit_nxt;
    ded_r        <= ded_nxt;
    res_credit_r <= res_credit_nxt;
    res_save_r   <= res_save_nxt;
    out_ch_r     <= out_ch_nxt;
    out_credit_r <= out_credit_nxt;
    out_save_r   <= out_save_nxt;
  end

  // The store starts at zero credit for every channel.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < int'(CHANNELS); i++) begin
        store_r[i] <= '0;
      end
    end else if (store_we) begin
      store_r[ch_idx] <= res_credit_r;
    end
  end

  // Configuration registers; writes to an unused index are dropped.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      power_mode_r <= pccm_pkg::POWER_MODE_RST;
      base_r       <= pccm_pkg::BASE_RST;
      mult_r       <= pccm_pkg::MULT_RST;
    end else if (cfg_we) begin
      case (paddr[3:2])
        pccm_pkg::REG_POWER_MODE:   power_mode_r <= pwdata[0];
        pccm_pkg::REG_BASE_CURRENT: base_r       <= pwdata[CU_W-1:0];
        pccm_pkg::REG_OC_MULTIPLE:  mult_r       <= pwdata[MU_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      pccm_pkg::REG_POWER_MODE:   prdata = DW'(power_mode_r);
      pccm_pkg::REG_BASE_CURRENT: prdata = DW'(base_r);
      pccm_pkg::REG_OC_MULTIPLE:  prdata = DW'(mult_r);
      default:                    prdata = '0;
    endcase
  end

  assign in_ready           = (state_r == ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_result_channel = out_ch_r;
  assign out_credit_tenths  = out_credit_r;
  assign out_save_request   = out_save_r;

endmodule

// ===== hw/rtl/pccm_checker.sv =====
// ============================================================================
// pccm_checker: port-level checks for the credit meter
// Watches the event and result channels and is bound to the top level.
// ============================================================================
module pccm_checker #(
  parameter int unsigned CHANNELS = pccm_pkg::CHANNELS_DEF
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [pccm_pkg::CHANNEL_W-1:0]  out_result_channel,
  input logic [pccm_pkg::CREDIT_W-1:0]   out_credit_tenths,
  input logic                            out_save_request
);

  localparam int unsigned CHK_W = pccm_pkg::CHANNEL_W + 1;
  localparam logic [CHK_W-1:0] CH_LIMIT = CHK_W'(CHANNELS);

  // A stalled result word holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_channel) &&
    $stable(out_credit_tenths) && $stable(out_save_request))
    else $error("result word changed while stalled");

  // Credit never leaves its saturation limit.
  a_credit_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_credit_tenths <= pccm_pkg::CREDIT_MAX)
    else $error("credit above limit");

  // A channel outside the store reports nothing.
  a_bad_channel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ({1'b0, out_result_channel} >= CH_LIMIT) |->
    (out_credit_tenths == '0) && !out_save_request)
    else $error("out-of-range channel reported credit");

  // The block works on one word at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a second word while busy");

endmodule

bind prepaid_channel_credit_meter_core pccm_checker #(
  .CHANNELS (CHANNELS)
) u_pccm_checker (.*);

// ===== tb/sv/tb.sv =====
// ============================================================================
// tb: self-checking bench for prepaid_channel_credit_meter_core
// Drives credit-add and billing-tick words with random idling on both
// channels. A built-in predictor keeps its own credit balances and register
// copies and checks every result word, field by field, in order.
// ============================================================================
`timescale 1ns / 100ps

module tb;

  localparam int unsigned CH_W          = pccm_pkg::CHANNEL_W;
  localparam int unsigned MN_W          = pccm_pkg::MINUTES_W;
  localparam int unsigned CU_W          = pccm_pkg::CURRENT_W;
  localparam int unsigned CR_W          = pccm_pkg::CREDIT_W;
  localparam int unsigned MU_W          = pccm_pkg::MULT_W;
  localparam int unsigned DW            = pccm_pkg::PDATA_W;
  localparam int unsigned NUM_CH        = pccm_pkg::CHANNELS_DEF;
  // Margin of quiet cycles after the last result, allowing for a current-billed tick.
  localparam int unsigned SETTLE_CYCLES = 30;
  // Cycles without any handshake before the run is declared hung.
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned MAX_SHOWN     = 10;
  // Word index just past the last register; writes there must be dropped.
  localparam logic [1:0]  REG_UNUSED    = 2'd3;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic [CR_W-1:0] credit;
    logic            save;
  } credit_report_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic                         in_req_type;
  logic [CH_W-1:0]              in_channel;
  logic [MN_W-1:0]              in_add_minutes;
  logic [CU_W-1:0]              in_current_sample;
  logic                         in_fuse_ok;
  logic                         in_over_current;
  logic                         out_valid;
  logic                         out_ready;
  logic [CH_W-1:0]              out_result_channel;
  logic [CR_W-1:0]              out_credit_tenths;
  logic                         out_save_request;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [pccm_pkg::PADDR_W-1:0] paddr;
  logic [DW-1:0]                pwdata;
  logic [DW-1:0]                prdata;
  logic                         pready;

  // Predictor state: balances per channel and shadow copies of the registers.
  logic [CR_W-1:0]      balance [NUM_CH];
  logic                 model_power;
  logic [CU_W-1:0]      model_base;
  logic [MU_W-1:0]      model_mult;

  // Result words predicted at acceptance, oldest first.
  credit_report_t       reports_due [$];

  // When low, both sides run without gaps or stalls.
  bit                   idle_en = 1'b1;
  int unsigned          errors = 0;
  int unsigned          quiet = 0;
  int unsigned          n_add = 0;
  int unsigned          n_tick = 0;
  int unsigned          n_ignored = 0;
  int unsigned          n_cleared = 0;
  int unsigned          n_capped = 0;
  int unsigned          n_writes = 0;
  int unsigned          n_results = 0;

  prepaid_channel_credit_meter_core DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_channel         (in_channel),
    .in_add_minutes     (in_add_minutes),
    .in_current_sample  (in_current_sample),
    .in_fuse_ok         (in_fuse_ok),
    .in_over_current    (in_over_current),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result_channel (out_result_channel),
    .out_credit_tenths  (out_credit_tenths),
    .out_save_request   (out_save_request),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  // Charge for one billing minute, in tenths, capped at the 8-bit maximum
  // instead of wrapping.
  function automatic int unsigned minute_charge(input logic [CU_W-1:0] cur,
                                                input logic fuse, input logic oc);
    int unsigned d;
    if (model_power != pccm_pkg::POWER_MODE_ON)
      return 32'(pccm_pkg::PLAIN_RATE);
    if (oc)
      d = 32'd10 * 32'(model_mult);
    else if (fuse && cur > model_base) begin
      if (model_base == '0)
        d = 32'(pccm_pkg::DEDUCT_MAX);
      else
        d = (32'd10 * 32'(cur)) / 32'(model_base);
    end else
      d = 32'(pccm_pkg::PLAIN_RATE);
    if (d > 32'(pccm_pkg::DEDUCT_MAX)) begin
      n_capped++;
      d = 32'(pccm_pkg::DEDUCT_MAX);
    end
    return d;
  endfunction

  // Applies one accepted event to the balances and returns its result word.
  function automatic credit_report_t bill_event(input logic req,
                                                input logic [CH_W-1:0] ch,
                                                input logic [MN_W-1:0] mins,
                                                input logic [CU_W-1:0] cur,
                                                input logic fuse, input logic oc);
    credit_report_t rep;
    int unsigned    bal;
    int unsigned    charge;
    rep.ch     = ch;
    rep.credit = '0;
    rep.save   = 1'b0;
    if (req == pccm_pkg::REQ_ADD) n_add++;
    else n_tick++;
    if (32'(ch) >= NUM_CH) begin
      // Channels past the last one leave every balance alone.
      n_ignored++;
      return rep;
    end
    bal = 32'(balance[ch]);
    if (req == pccm_pkg::REQ_ADD) begin
      bal = bal + 32'd10 * 32'(mins);
      if (bal > 32'(pccm_pkg::CREDIT_MAX)) bal = 32'(pccm_pkg::CREDIT_MAX);
      rep.save = 1'b1;
    end else begin
      charge = minute_charge(cur, fuse, oc);
      if (bal > charge)
        bal = bal - charge;
      else if (bal != 0) begin
        // Credit used up: cleared, and the new value must be saved.
        bal = 0;
        rep.save = 1'b1;
        n_cleared++;
      end
    end
    balance[ch] = bal[CR_W-1:0];
    rep.credit  = bal[CR_W-1:0];
    return rep;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers. Every task starts and ends just after a falling edge.
  // --------------------------------------------------------------------------

  // Offers one event word and records its predicted result at acceptance.
  // in_valid stays high between back-to-back words and drops only for a gap or a settle.
  task automatic send_event(input logic req, input logic [CH_W-1:0] ch,
                            input logic [MN_W-1:0] mins,
                            input logic [CU_W-1:0] cur,
                            input logic fuse, input logic oc);
    int unsigned gap;
    if (idle_en && $urandom_range(99) < 20) begin
      in_valid = 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(negedge clk);
    end
    in_req_type       = req;
    in_channel        = ch;
    in_add_minutes    = mins;
    in_current_sample = cur;
    in_fuse_ok        = fuse;
    in_over_current   = oc;
    in_valid          = 1'b1;
    do @(posedge clk); while (!in_ready);
    reports_due.push_back(bill_event(req, ch, mins, cur, fuse, oc));
    @(negedge clk);
  endtask

  // Lets every outstanding word come back and the sequencer fall idle.
  task automatic settle_block();
    in_valid = 1'b0;
    while (reports_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register write: setup cycle, then access cycle, only while idle.
  task automatic write_cfg(input logic [1:0] idx, input logic [DW-1:0] value);
    settle_block();
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      pccm_pkg::REG_POWER_MODE:   model_power = value[0];
      pccm_pkg::REG_BASE_CURRENT: model_base  = value[CU_W-1:0];
      pccm_pkg::REG_OC_MULTIPLE:  model_mult  = value[MU_W-1:0];
      default: ;
    endcase
    n_writes++;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_billing(input logic pm, input logic [CU_W-1:0] base,
                             input logic [MU_W-1:0] mult);
    write_cfg(pccm_pkg::REG_POWER_MODE, {{(DW-1){1'b0}}, pm});
    write_cfg(pccm_pkg::REG_BASE_CURRENT, {{(DW-CU_W){1'b0}}, base});
    write_cfg(pccm_pkg::REG_OC_MULTIPLE, {{(DW-MU_W){1'b0}}, mult});
  endtask

  // Random event. Mostly valid channels and modest purchases so balances
  // stay in the range where ticks both deduct and clear; currents cluster
  // around the base so the divided rate spans small and capped charges.
  task automatic send_random_event();
    logic            req;
    logic [CH_W-1:0] ch;
    logic [MN_W-1:0] mins;
    logic [CU_W-1:0] cur;
    int              c;
    int unsigned     pick;
    req = ($urandom_range(99) < 35) ? pccm_pkg::REQ_ADD : pccm_pkg::REQ_TICK;
    if ($urandom_range(99) < 94) ch = CH_W'($urandom_range(0, NUM_CH - 1));
    else ch = CH_W'($urandom_range(NUM_CH, 15));
    pick = $urandom_range(99);
    if (pick < 70) mins = MN_W'($urandom_range(0, 60));
    else if (pick < 90) mins = MN_W'($urandom_range(0, 999));
    else mins = MN_W'($urandom_range(0, 1023));
    pick = $urandom_range(99);
    if (pick < 40)
      c = int'($urandom_range(0, 4095));
    else if (pick < 70)
      c = int'(model_base) + int'($urandom_range(0, 60)) - 30;
    else
      c = (int'(model_base) * int'($urandom_range(0, 120))) / 4;
    if (c < 0) c = 0;
    if (c > 4095) c = 4095;
    cur = c[CU_W-1:0];
    send_event(req, ch, mins, cur, $urandom_range(99) < 80, $urandom_range(99) < 25);
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------

  task automatic note_failure(input string what, input credit_report_t want);
    errors++;
    if (errors <= MAX_SHOWN)
      $display("[%0t] %s: expected ch %0d credit %0d save %0d, got ch %0d credit %0d save %0d",
               $realtime, what, want.ch, want.credit, want.save,
               out_result_channel, out_credit_tenths, out_save_request);
  endtask

  always @(posedge clk) begin : check_result
    credit_report_t want;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (reports_due.size() == 0) begin
        note_failure("unexpected result word", '0);
      end else begin
        want = reports_due.pop_front();
        if (out_result_channel !== want.ch || out_credit_tenths !== want.credit ||
            out_save_request !== want.save)
          note_failure("result mismatch", want);
      end
    end
  end

  // Receiver: stalls about one cycle in five while idling is enabled.
  always @(negedge clk)
    out_ready = !idle_en || ($urandom_range(99) >= 20);

  // Watchdog on cycles in which no word and no register write moves.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("[%0t] watchdog: no handshake for %0d cycles, %0d results pending",
               $realtime, QUIET_LIMIT, reports_due.size());
      $display("** prepaid_channel_credit_meter_core: FAILED **");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Fresh balances are zero; a tick on zero credit stays zero, no save.
  task automatic test_reset_state();
    send_event(pccm_pkg::REQ_TICK, 4'd0, '0, '0, 1'b1, 1'b0);
    send_event(pccm_pkg::REQ_TICK, 4'd3, '0, 12'd4095, 1'b1, 1'b1);
  endtask

  // Purchases: full range, saturation at the credit ceiling, zero minutes,
  // and channels past the last one.
  task automatic test_credit_adds();
    send_event(pccm_pkg::REQ_ADD, 4'd0, 10'd999, '0, 1'b0, 1'b0);
    send_event(pccm_pkg::REQ_ADD, 4'd0, 10'd1023, 12'd4095, 1'b1, 1'b1);
    send_event(pccm_pkg::REQ_ADD, 4'd9, 10'd0, '0, 1'b0, 1'b0);
    send_event(pccm_pkg::REQ_ADD, 4'd10, 10'd5, '0, 1'b0, 1'b0);
    send_event(pccm_pkg::REQ_TICK, 4'd15, 10'd1023, 12'd4095, 1'b1, 1'b1);
    send_event(pccm_pkg::REQ_ADD, 4'd1, 10'd1, '0, 1'b0, 1'b0);
  endtask

  // Plain-time billing ignores current and over-current; credit equal to
  // the charge is cleared with a save request.
  task automatic test_plain_ticks();
    send_event(pccm_pkg::REQ_TICK, 4'd1, '0, 12'd50, 1'b1, 1'b0);
    send_event(pccm_pkg::REQ_ADD, 4'd2, 10'd2, '0, 1'b0, 1'b0);
    send_event(pccm_pkg::REQ_TICK, 4'd2, '0, 12'd4095, 1'b1, 1'b1);
    send_event(pccm_pkg::REQ_TICK, 4'd2, '0, 12'd0, 1'b0, 1'b0);
  endtask

  // Current-based billing against channel 0, which holds full credit.
  task automatic test_power_billing();
    set_billing(pccm_pkg::POWER_MODE_ON, 12'd100, 5'd3);
    send_event(pccm_pkg::REQ_TICK, 4'd0, '0, 12'd0, 1'b1, 1'b1);
    // A large current over the base caps the charge at the 8-bit maximum.
    send_event(pccm_pkg::REQ_TICK, 4'd0, '0, 12'd4095, 1'b1, 1'b0);
    send_event(pccm_pkg::REQ_TICK, 4'd0, '0, 12'd100, 1'b1, 1'b0);
    send_event(pccm_pkg::REQ_TICK, 4'd0, '0, 12'd4095, 1'b0, 1'b0);
    // Zero multiple: over-current costs nothing and nothing is saved.
    write_cfg(pccm_pkg::REG_OC_MULTIPLE, 32'd0);
    send_event(pccm_pkg::REQ_TICK, 4'd0, '0, 12'd300, 1'b1, 1'b1);
    write_cfg(pccm_pkg::REG_OC_MULTIPLE, 32'd31);
    send_event(pccm_pkg::REQ_TICK, 4'd0, '0, 12'd0, 1'b0, 1'b1);
    // Zero base current: any current above it is charged the maximum.
    write_cfg(pccm_pkg::REG_BASE_CURRENT, 32'd0);
    send_event(pccm_pkg::REQ_TICK, 4'd0, '0, 12'd1, 1'b1, 1'b0);
    send_event(pccm_pkg::REQ_TICK, 4'd0, '0, 12'd0, 1'b1, 1'b0);
    write_cfg(pccm_pkg::REG_BASE_CURRENT, 32'd4095);
    send_event(pccm_pkg::REQ_TICK, 4'd0, '0, 12'd4095, 1'b1, 1'b0);
    write_cfg(pccm_pkg::REG_BASE_CURRENT, 32'd1);
    send_event(pccm_pkg::REQ_TICK, 4'd0, '0, 12'd2, 1'b1, 1'b0);
    send_event(pccm_pkg::REQ_TICK, 4'd0, '0, 12'd4095, 1'b1, 1'b0);
  endtask

  // Writes past the register list are dropped, and only the register's own
  // bits of a full data word take effect.
  task automatic test_register_decode();
    write_cfg(REG_UNUSED, 32'hFFFF_FFFF);
    write_cfg(pccm_pkg::REG_POWER_MODE, 32'hFFFF_FFFE);
    send_event(pccm_pkg::REQ_TICK, 4'd0, '0, 12'd4095, 1'b1, 1'b1);
    write_cfg(pccm_pkg::REG_BASE_CURRENT, 32'hFFFF_F064);
    write_cfg(pccm_pkg::REG_OC_MULTIPLE, 32'hFFFF_FFE3);
    write_cfg(pccm_pkg::REG_POWER_MODE, 32'hFFFF_FFFF);
  endtask

  // Random traffic across a series of register settings, extremes included.
  task automatic test_random_settings();
    logic            pm_set [7];
    logic [CU_W-1:0] base_set [7];
    logic [MU_W-1:0] mult_set [7];
    pm_set   = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};
    base_set = '{12'd100, 12'd100, 12'd1, 12'd4095, 12'd0, 12'd37, 12'd4095};
    mult_set = '{5'd3, 5'd3, 5'd0, 5'd31, 5'd25, 5'd7, 5'd0};
    for (int p = 0; p < 7; p++) begin
      if (p == 5) base_set[p] = CU_W'($urandom_range(1, 4095));
      set_billing(pm_set[p], base_set[p], mult_set[p]);
      repeat (160) send_random_event();
    end
  endtask

  // Input always offered and output never stalled: words go back to back.
  task automatic test_back_to_back();
    set_billing(pccm_pkg::POWER_MODE_ON, 12'd200, 5'd12);
    idle_en = 1'b0;
    repeat (150) send_random_event();
    settle_block();
    idle_en = 1'b1;
  endtask

  initial begin
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_req_type       = pccm_pkg::REQ_ADD;
    in_channel        = '0;
    in_add_minutes    = '0;
    in_current_sample = '0;
    in_fuse_ok        = 1'b0;
    in_over_current   = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    model_power       = pccm_pkg::POWER_MODE_RST;
    model_base        = pccm_pkg::BASE_RST;
    model_mult        = pccm_pkg::MULT_RST;
    foreach (balance[i]) balance[i] = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_credit_adds();
    test_plain_ticks();
    test_power_billing();
    test_register_decode();
    test_random_settings();
    test_back_to_back();
    settle_block();

    $display("Covered %0d credit adds and %0d billing ticks, %0d on absent channels,",
             n_add, n_tick, n_ignored);
    $display("%0d credits run out, %0d capped charges, %0d register writes, %0d results.",
             n_cleared, n_capped, n_writes, n_results);
    if (errors == 0 && reports_due.size() == 0) begin
      $display("** prepaid_channel_credit_meter_core: PASSED **");
    end else begin
      $display("%0d failures, %0d results missing", errors, reports_due.size());
      $display("** prepaid_channel_credit_meter_core: FAILED **");
    end
    $finish;
  end

endmodule
